// ----- rtl/fafe_pkg.sv -----
// ----------------------------------------------------------------------------
// fafe_pkg: shared definitions for the frame allocator
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package fafe_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 6;
  localparam int TAG_W   = 16;
  localparam int STAMP_W = 32;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 24;

  // Parameter defaults.
  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_TAG_BITS   = 16;

  // Reset value of the frame count register.
  localparam logic [CFG_W-1:0] FRAMES_RESET = 7'd64;

  // Operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes.
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

endpackage

// ----- rtl/frame_allocator_fifo_evict_top.sv -----
// ----------------------------------------------------------------------------
// frame_allocator_fifo_evict_top: frame allocator with load-order eviction
// Hands out memory frames to loaded pages, evicting the oldest load when full.
// ----------------------------------------------------------------------------
// Each input transfer is one request. A load (tuser 0) takes the
// lowest-numbered free frame among frames 0 .. frames_in_use-1; if none is
// free it evicts the resident page with the oldest load stamp (lowest frame
// on a tie) and returns that page's tag. A release (tuser 1) frees a frame,
// or reports status 1 if the index is at or above the effective frame count. All frame
// state sits in one single-port-write memory with a registered read, which a
// load walks one frame per cycle, stopping early when a free frame turns up;
// a release does not scan. After reset the memory is cleared one entry per
// cycle before the first request is accepted; configuration transfers are
// taken at any time. A new request is accepted while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module frame_allocator_fifo_evict_top
  import fafe_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write channel: frames_in_use.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  // Request stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [5:0] frame_index, [21:6] page_tag, [23:22] zero
  input  logic [0:0]        in_tuser,   // [0] op
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // [5:0] frame_out, [6] evicted,
                                        // [22:7] evicted_tag, [23] status
);

  // Address and counter widths follow the table depth.
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = AW + 1;
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;

  // Control states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // One table entry per frame.
  typedef struct packed {
    logic                used;
    logic [STAMP_W-1:0]  stamp;
    logic [TAG_BITS-1:0] owner;
  } entry_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [1:0]          state_r,     state_nxt;
  logic [CFG_W-1:0]    fiu_r,       fiu_nxt;
  logic [STAMP_W-1:0]  load_cnt_r,  load_cnt_nxt;
  logic [AW-1:0]       clr_r,       clr_nxt;
  logic                op_r,        op_nxt;
  logic [IDX_W-1:0]    idx_r,       idx_nxt;
  logic [TAG_BITS-1:0] tag_r,       tag_nxt;
  logic [CW-1:0]       issue_r,     issue_nxt;
  logic [CW-1:0]       chk_r,       chk_nxt;
  logic                rd_vld_r,    rd_vld_nxt;
  logic                found_r,     found_nxt;
  logic [AW-1:0]       free_idx_r,  free_idx_nxt;
  logic [STAMP_W-1:0]  min_stamp_r, min_stamp_nxt;
  logic [AW-1:0]       min_idx_r,   min_idx_nxt;
  logic [TAG_BITS-1:0] min_owner_r, min_owner_nxt;
  logic                out_vld_r,   out_vld_nxt;
  logic [OUT_DW-1:0]   out_data_r,  out_data_nxt;

  // Frame table.
  entry_t              mem [MAX_FRAMES];
  entry_t              rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  entry_t              mem_wd;
  logic [AW-1:0]       mem_ra;

  // --------------------------------------------------------------------------
  // Effective frame count: zero acts as one, large values clamp to the table.
  // --------------------------------------------------------------------------
  logic [NW-1:0] cfg_ext;
  logic [NW-1:0] max_ext;
  logic [NW-1:0] n_full;
  logic [CW-1:0] n_eff;
  logic          rel_oob;
  logic          issue_more;
  logic          last_chk;
  logic          can_out;
  logic          in_xfer;
  logic          load_sel_free;
  logic [AW-1:0] load_frame;

  assign cfg_ext    = NW'(fiu_r);
  assign max_ext    = NW'(MAX_FRAMES);
  assign n_full     = (cfg_ext == '0) ? NW'(1) : ((cfg_ext > max_ext) ? max_ext : cfg_ext);
  assign n_eff      = CW'(n_full);
  assign rel_oob    = NW'(idx_r) >= n_full;
  assign issue_more = issue_r < n_eff;
  assign last_chk   = chk_r == (n_eff - CW'(1));

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == S_IDLE;
  assign in_xfer    = in_tvalid && in_tready;
  assign can_out    = !out_vld_r || out_tready;

  assign load_sel_free = found_r;
  assign load_frame    = found_r ? free_idx_r : min_idx_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign mem_ra = issue_r[AW-1:0];

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    fiu_nxt       = fiu_r;
    load_cnt_nxt  = load_cnt_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    tag_nxt       = tag_r;
    issue_nxt     = issue_r;
    chk_nxt       = chk_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    free_idx_nxt  = free_idx_r;
    min_stamp_nxt = min_stamp_r;
    min_idx_nxt   = min_idx_r;
    min_owner_nxt = min_owner_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = clr_r;
    mem_wd        = '0;

    if (cfg_valid && cfg_ready) begin
      fiu_nxt = cfg_data;
    end

    case (state_r)
      S_CLEAR: begin
        // Sweep the table so that every frame starts free.
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_tuser[0];
          idx_nxt   = in_tdata[IDX_W-1:0];
          tag_nxt   = TAG_BITS'(in_tdata[IDX_W +: TAG_W]);
          issue_nxt = '0;
          chk_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (in_tuser[0] == OP_RELEASE) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle and examine the entry read the cycle before.
        if (issue_more) begin
          issue_nxt  = issue_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          chk_nxt = chk_r + CW'(1);
          if (!rd_data_r.used) begin
            found_nxt    = 1'b1;
            free_idx_nxt = chk_r[AW-1:0];
            state_nxt    = S_DONE;
          end else begin
            if ((chk_r == '0) || (rd_data_r.stamp < min_stamp_r)) begin
              min_stamp_nxt = rd_data_r.stamp;
              min_idx_nxt   = chk_r[AW-1:0];
              min_owner_nxt = rd_data_r.owner;
            end
            if (last_chk) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        // Commit the table update and the result together once the output
        // register is free.
        if (can_out) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
          if (op_r == OP_LOAD) begin
            mem_we       = 1'b1;
            mem_wa       = load_frame;
            mem_wd.used  = 1'b1;
            mem_wd.stamp = load_cnt_r;
            mem_wd.owner = tag_r;
            if (load_cnt_r != '1) begin
              load_cnt_nxt = load_cnt_r + STAMP_W'(1);
            end
            out_data_nxt = {ST_OK,
                            load_sel_free ? {TAG_W{1'b0}} : TAG_W'(min_owner_r),
                            !load_sel_free,
                            IDX_W'(load_frame)};
          end else begin
            if (!rel_oob) begin
              mem_we = 1'b1;
              mem_wa = AW'(idx_r);
            end
            out_data_nxt = {rel_oob ? ST_RANGE : ST_OK, {TAG_W{1'b0}}, 1'b0, idx_r};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame table: one write port, one registered read port.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      fiu_r      <= FRAMES_RESET;
      load_cnt_r <= '0;
      clr_r      <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fiu_r      <= fiu_nxt;
      load_cnt_r <= load_cnt_nxt;
      clr_r      <= clr_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    tag_r       <= tag_nxt;
    issue_r     <= issue_nxt;
    chk_r       <= chk_nxt;
    found_r     <= found_nxt;
    free_idx_r  <= free_idx_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_idx_r   <= min_idx_nxt;
    min_owner_r <= min_owner_nxt;
    out_data_r  <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The table is never written while a scan is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("table written during scan");

  // Every entry examined by the scan lies inside the active frame range.
  a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_vld_r) |-> (chk_r < n_eff))
    else $error("scan examined a frame beyond the active range");

  // An eviction and a range error never come in the same result.
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r[IDX_W]) |-> (out_data_r[OUT_DW-1] == ST_OK))
    else $error("eviction reported with error status");

  // The load counter never goes backward.
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (load_cnt_r >= $past(load_cnt_r)))
    else $error("load counter decreased");
`endif

endmodule
